@@ rtl/cbt_pkg.sv @@
// Shared types and constants for the CSV byte tokenizer.
`timescale 1ns / 1ps

package cbt_pkg;

  // Parser phase: three BOM bytes, then body, then error hold
  typedef enum logic [2:0] {
    PH_BOM0  = 3'd0,
    PH_BOM1  = 3'd1,
    PH_BOM2  = 3'd2,
    PH_BODY  = 3'd3,
    PH_ERROR = 3'd4
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    K_FIELD_BYTE = 3'd0,
    K_FIELD_END  = 3'd1,
    K_RECORD_END = 3'd2,
    K_ERROR      = 3'd3,
    K_DONE       = 3'd4
  } kind_t;

  // Error codes
  typedef enum logic [1:0] {
    E_NO_BOM       = 2'd0,
    E_AFTER_QUOTE  = 2'd1,
    E_STRAY_QUOTE  = 2'd2,
    E_UNTERMINATED = 2'd3
  } err_t;

  // Byte order mark and special characters
  localparam logic [7:0] BOM_B0   = 8'hEF;
  localparam logic [7:0] BOM_B1   = 8'hBB;
  localparam logic [7:0] BOM_B2   = 8'hBF;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // One result transaction
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [31:0] line_number;
    err_t        error_code;
    logic        last_of_run;
  } res_t;

endpackage

@@ rtl/csv_byte_tokenizer.sv @@
// Each result is registered in the result queue when its input is accepted.
// Throughput: one byte per cycle; an end item yields up to two results, so the
//   3-entry result queue absorbs it and input stalls while two or more results wait.
// Each byte updates the parse flags through combinational logic.
// Reset (synchronous, active high) empties the queue, returns to BOM checking,
//   clears the parse flags and sets both line counters to one.
`timescale 1ns / 1ps

module csv_byte_tokenizer #(
  parameter int LINE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  out_byte,
  output logic [31:0] line_number,
  output logic [1:0]  error_code,
  output logic        last_of_run
);

  localparam int QDEPTH = 3;

  // Parse state
  cbt_pkg::phase_t      phase, phase_next;
  logic                 in_quotes, in_quotes_next;
  logic                 quote_pending, quote_pending_next;
  logic                 quote_closed, quote_closed_next;
  logic                 field_started, field_started_next;
  logic                 field_has_data, field_has_data_next;
  logic                 record_has_comma, record_has_comma_next;
  logic                 skip_line_feed, skip_line_feed_next;
  logic [LINE_BITS-1:0] current_line, current_line_next;
  logic [LINE_BITS-1:0] record_start_line, record_start_line_next;

  // Result queue
  cbt_pkg::res_t q [QDEPTH];
  cbt_pkg::res_t q_next [QDEPTH];
  logic [1:0]    count, count_next;

  logic          in_acc, out_acc;
  logic [LINE_BITS-1:0] line_inc;
  cbt_pkg::res_t r0, r1;
  logic          r0_valid, r1_valid;
  logic          err_hit;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (count > 2'd1);
  assign line_inc = (current_line == '1) ? current_line : current_line + 1'b1;

  // Decode one transaction into results and parse flag updates
  always_comb begin
    logic handled;
    logic qc_eff;
    cbt_pkg::res_t blank;
    blank = '{kind: cbt_pkg::K_FIELD_BYTE, out_byte: 8'd0, line_number: 32'd0,
              error_code: cbt_pkg::E_NO_BOM, last_of_run: 1'b0};
    r0 = blank;
    r1 = blank;
    r0_valid = 1'b0;
    r1_valid = 1'b0;
    err_hit = 1'b0;
    handled = 1'b0;
    qc_eff = 1'b0;
    in_quotes_next = in_quotes;
    quote_pending_next = quote_pending;
    quote_closed_next = quote_closed;
    field_started_next = field_started;
    field_has_data_next = field_has_data;
    record_has_comma_next = record_has_comma;
    skip_line_feed_next = skip_line_feed;
    current_line_next = current_line;
    record_start_line_next = record_start_line;

    if (in_acc && end_of_input) begin
      // Flush, report done, return to reset values
      if (phase == cbt_pkg::PH_BOM0 || phase == cbt_pkg::PH_BOM1 ||
          phase == cbt_pkg::PH_BOM2) begin
        r0_valid = 1'b1;
        r0.kind = cbt_pkg::K_ERROR;
        r0.line_number = 32'd1;
        r0.error_code = cbt_pkg::E_NO_BOM;
      end else if (phase == cbt_pkg::PH_BODY) begin
        if (in_quotes && !quote_pending) begin
          r0_valid = 1'b1;
          r0.kind = cbt_pkg::K_ERROR;
          r0.line_number = 32'(current_line);
          r0.error_code = cbt_pkg::E_UNTERMINATED;
        end else if (field_started || quote_closed || in_quotes || field_has_data ||
                     record_has_comma) begin
          r0_valid = 1'b1;
          r0.kind = cbt_pkg::K_RECORD_END;
          r0.line_number = 32'(record_start_line);
        end
      end
      if (r0_valid) begin
        r1_valid = 1'b1;
        r1.kind = cbt_pkg::K_DONE;
        r1.last_of_run = 1'b1;
      end else begin
        r0_valid = 1'b1;
        r0.kind = cbt_pkg::K_DONE;
        r0.last_of_run = 1'b1;
      end
      in_quotes_next = 1'b0;
      quote_pending_next = 1'b0;
      quote_closed_next = 1'b0;
      field_started_next = 1'b0;
      field_has_data_next = 1'b0;
      record_has_comma_next = 1'b0;
      skip_line_feed_next = 1'b0;
      current_line_next = LINE_BITS'(1);
      record_start_line_next = LINE_BITS'(1);
    end else if (in_acc && (phase == cbt_pkg::PH_BOM0 || phase == cbt_pkg::PH_BOM1 ||
                            phase == cbt_pkg::PH_BOM2)) begin
      // Check the byte order mark
      if (!((phase == cbt_pkg::PH_BOM0 && data_byte == cbt_pkg::BOM_B0) ||
            (phase == cbt_pkg::PH_BOM1 && data_byte == cbt_pkg::BOM_B1) ||
            (phase == cbt_pkg::PH_BOM2 && data_byte == cbt_pkg::BOM_B2))) begin
        err_hit = 1'b1;
        r0_valid = 1'b1;
        r0.kind = cbt_pkg::K_ERROR;
        r0.line_number = 32'd1;
        r0.error_code = cbt_pkg::E_NO_BOM;
        r0.last_of_run = 1'b1;
      end
    end else if (in_acc && phase == cbt_pkg::PH_BODY) begin
      // Swallow the LF of a CRLF pair
      if (skip_line_feed) begin
        skip_line_feed_next = 1'b0;
        if (data_byte == cbt_pkg::CH_LF) handled = 1'b1;
      end
      // Quoted field content
      if (!handled && in_quotes) begin
        if (quote_pending) begin
          quote_pending_next = 1'b0;
          if (data_byte == cbt_pkg::CH_QUOTE) begin
            field_has_data_next = 1'b1;
            r0_valid = 1'b1;
            r0.out_byte = cbt_pkg::CH_QUOTE;
            handled = 1'b1;
          end else begin
            in_quotes_next = 1'b0;
            quote_closed_next = 1'b1;
            qc_eff = 1'b1;
          end
        end else begin
          handled = 1'b1;
          if (data_byte == cbt_pkg::CH_QUOTE) begin
            quote_pending_next = 1'b1;
          end else begin
            field_has_data_next = 1'b1;
            if (data_byte == cbt_pkg::CH_LF) current_line_next = line_inc;
            r0_valid = 1'b1;
            r0.out_byte = data_byte;
          end
        end
      end else begin
        qc_eff = quote_closed;
      end
      // Unquoted handling
      if (!handled) begin
        if (qc_eff && data_byte != cbt_pkg::CH_COMMA && data_byte != cbt_pkg::CH_CR &&
            data_byte != cbt_pkg::CH_LF) begin
          err_hit = 1'b1;
          r0_valid = 1'b1;
          r0.kind = cbt_pkg::K_ERROR;
          r0.line_number = 32'(current_line);
          r0.error_code = cbt_pkg::E_AFTER_QUOTE;
        end else if (data_byte == cbt_pkg::CH_QUOTE) begin
          if (field_started || field_has_data) begin
            err_hit = 1'b1;
            r0_valid = 1'b1;
            r0.kind = cbt_pkg::K_ERROR;
            r0.line_number = 32'(current_line);
            r0.error_code = cbt_pkg::E_STRAY_QUOTE;
          end else begin
            in_quotes_next = 1'b1;
            field_started_next = 1'b1;
          end
        end else if (data_byte == cbt_pkg::CH_COMMA) begin
          field_started_next = 1'b0;
          field_has_data_next = 1'b0;
          quote_closed_next = 1'b0;
          record_has_comma_next = 1'b1;
          r0_valid = 1'b1;
          r0.kind = cbt_pkg::K_FIELD_END;
        end else if (data_byte == cbt_pkg::CH_CR || data_byte == cbt_pkg::CH_LF) begin
          if (record_has_comma || field_has_data) begin
            r0_valid = 1'b1;
            r0.kind = cbt_pkg::K_RECORD_END;
            r0.line_number = 32'(record_start_line);
          end
          in_quotes_next = 1'b0;
          quote_pending_next = 1'b0;
          quote_closed_next = 1'b0;
          field_started_next = 1'b0;
          field_has_data_next = 1'b0;
          record_has_comma_next = 1'b0;
          current_line_next = line_inc;
          record_start_line_next = line_inc;
          skip_line_feed_next = (data_byte == cbt_pkg::CH_CR);
        end else begin
          field_started_next = 1'b1;
          field_has_data_next = 1'b1;
          r0_valid = 1'b1;
          r0.out_byte = data_byte;
        end
      end
      r0.last_of_run = 1'b1;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (in_acc) begin
      if (end_of_input) begin
        phase_next = cbt_pkg::PH_BOM0;
      end else if (err_hit) begin
        phase_next = cbt_pkg::PH_ERROR;
      end else begin
        unique case (phase)
          cbt_pkg::PH_BOM0:  phase_next = cbt_pkg::PH_BOM1;
          cbt_pkg::PH_BOM1:  phase_next = cbt_pkg::PH_BOM2;
          cbt_pkg::PH_BOM2:  phase_next = cbt_pkg::PH_BODY;
          cbt_pkg::PH_BODY:  phase_next = cbt_pkg::PH_BODY;
          cbt_pkg::PH_ERROR: phase_next = cbt_pkg::PH_ERROR;
          default:           phase_next = cbt_pkg::PH_ERROR;
        endcase
      end
    end
  end

  // Pop the head, then append new results
  always_comb begin
    logic [1:0] base;
    base = count;
    for (int i = 0; i < QDEPTH; i++) q_next[i] = q[i];
    if (out_acc) begin
      for (int i = 0; i < QDEPTH - 1; i++) q_next[i] = q[i+1];
      base = count - 2'd1;
    end
    if (r0_valid) begin
      for (int i = 0; i < QDEPTH; i++) begin
        if (2'(i) == base) q_next[i] = r0;
      end
    end
    if (r1_valid) begin
      for (int i = 0; i < QDEPTH; i++) begin
        if (2'(i) == base + 2'd1) q_next[i] = r1;
      end
    end
    count_next = base + {1'b0, r0_valid} + {1'b0, r1_valid};
  end

  // Hold queue payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) q[i] <= q_next[i];
  end

  // Advance control and parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      phase <= cbt_pkg::PH_BOM0;
      in_quotes <= 1'b0;
      quote_pending <= 1'b0;
      quote_closed <= 1'b0;
      field_started <= 1'b0;
      field_has_data <= 1'b0;
      record_has_comma <= 1'b0;
      skip_line_feed <= 1'b0;
      current_line <= LINE_BITS'(1);
      record_start_line <= LINE_BITS'(1);
    end else begin
      count <= count_next;
      phase <= phase_next;
      in_quotes <= in_quotes_next;
      quote_pending <= quote_pending_next;
      quote_closed <= quote_closed_next;
      field_started <= field_started_next;
      field_has_data <= field_has_data_next;
      record_has_comma <= record_has_comma_next;
      skip_line_feed <= skip_line_feed_next;
      current_line <= current_line_next;
      record_start_line <= record_start_line_next;
    end
  end

  // Drive the head of the queue
  assign out_valid   = (count != 2'd0);
  assign kind        = q[0].kind;
  assign out_byte    = q[0].out_byte;
  assign line_number = q[0].line_number;
  assign error_code  = q[0].error_code;
  assign last_of_run = q[0].last_of_run;

  // An end transaction always returns the parser to BOM checking
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    in_acc && end_of_input |=> phase == cbt_pkg::PH_BOM0)
    else $error("end transaction did not restart BOM check");

  // Bytes in error hold produce no results
  a_error_silent: assert property (@(posedge clk) disable iff (rst)
    in_acc && !end_of_input && phase == cbt_pkg::PH_ERROR |-> !r0_valid)
    else $error("result produced in error hold");

  // A record never starts after the current line
  a_line_order: assert property (@(posedge clk) disable iff (rst)
    record_start_line <= current_line)
    else $error("record start line ahead of current line");

  // Stream done is always the final result of its transaction
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == cbt_pkg::K_DONE |-> last_of_run)
    else $error("stream done not marked last");

endmodule
